// File: hw/rtl/bpli_pkg.sv
// bpli_pkg: shared types, codes and defaults for the one-level b+ leaf page index
// depends on nothing; used by every module in hw/rtl except bpli_ram
package bpli_pkg;

  localparam int LEAF_KEYS_DEF  = 4;
  localparam int LEAF_PAGES_DEF = 9;
  localparam int KEY_W          = 32;
  localparam int SPLIT_KEEP     = 2;
  localparam int STATUS_W       = 3;
  localparam int LEAF_W         = 4;
  localparam int FUNC_W         = 2;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SCAN   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LEAF     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SCAN_KEY = 3'd6;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] high_key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] value;
    logic [LEAF_W-1:0]       leaf;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic                route_step;
    logic                set_id;
    logic                load_rd;
    logic                load_wr;
    logic                ins_shift;
    logic                wr_step;
    logic                meta_upd;
    logic                sep_rd;
    logic                sep_wr;
    logic                scan_rd;
    logic                scan_adv;
    logic                next_leaf;
    logic                put;
    logic                put_pend;
    logic                put_last;
    logic [STATUS_W-1:0] put_status;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              inv;
    logic              route_more;
    logic              load_last;
    logic              dup;
    logic              full;
    logic              wr_last;
    logic              sep_done;
    logic              leaf_end;
    logic              leaf_more;
    logic              v_gt_hi;
    logic              v_ge_lo;
    logic              pend_valid;
    logic              out_free;
  } sts_t;

endpackage

// File: hw/rtl/bplus_leaf_page_index.sv
// bplus_leaf_page_index: top level, one fixed root over sorted leaf pages
// depends on bpli_pkg, bpli_ctrl, bpli_datapath (which holds bpli_ram)
//
//  channel | ports                          | moves
//  input   | in_valid, in_stall, in_item    | func, key, high_key
//  result  | out_valid, out_stall, out_item | status, value, leaf, last
//
// one item at a time; routing walks the root slots in order, one separator compare each
// leaf query: route, then respond; lookup: route, load the whole leaf, compare, respond
// insert: route, load the leaf, shift, write back, update metadata, refresh separators
// scan: route, then read keys in turn and hop leaf links until the chain ends or a key above the bound stops it;
//   the last result may wait in the output register while the next word is taken
// reset is synchronous: one empty leaf, no ram clearing pass; stalls hold the sequencer
module bplus_leaf_page_index #(
  parameter int LEAF_KEYS  = bpli_pkg::LEAF_KEYS_DEF,
  parameter int LEAF_PAGES = bpli_pkg::LEAF_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpli_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bpli_pkg::out_item_t out_item
);
  import bpli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bpli_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  bpli_datapath #(
    .LEAF_KEYS (LEAF_KEYS),
    .LEAF_PAGES(LEAF_PAGES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

// File: hw/rtl/bpli_ram.sv
// bpli_ram: generic single write port ram with registered read
// depends on nothing
module bpli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/bpli_datapath.sv
// bpli_datapath: root (child order, separators), leaf metadata, key ram, leaf buffer
// and result register; depends on bpli_pkg and bpli_ram
module bpli_datapath #(
  parameter int LEAF_KEYS  = bpli_pkg::LEAF_KEYS_DEF,
  parameter int LEAF_PAGES = bpli_pkg::LEAF_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bpli_pkg::in_item_t  in_item,
  input  bpli_pkg::cmd_t      cmd,
  output bpli_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output bpli_pkg::out_item_t out_item
);
  import bpli_pkg::*;

  localparam int PW    = $clog2(LEAF_PAGES);
  localparam int UW    = $clog2(LEAF_PAGES + 1);
  localparam int FW    = $clog2(LEAF_KEYS + 1);
  localparam int DEPTH = LEAF_PAGES * LEAF_KEYS;
  localparam int AW    = $clog2(DEPTH);

  logic [FUNC_W-1:0]       func_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] hi_r;
  logic [PW-1:0]           slot_r;
  logic [PW-1:0]           id_r;
  logic [PW-1:0]           hops_r;
  logic [FW-1:0]           idx_r;
  logic [UW-1:0]           sepi_r;
  logic signed [KEY_W-1:0] buf_r [LEAF_KEYS+1];
  logic signed [KEY_W-1:0] sep_r [LEAF_PAGES];
  logic [FW-1:0]           fill_r [LEAF_PAGES];
  logic [PW-1:0]           link_r [LEAF_PAGES];
  logic                    lv_r [LEAF_PAGES];
  logic [PW-1:0]           order_r [LEAF_PAGES];
  logic [UW-1:0]           used_r;
  logic                    pend_valid_r;
  logic signed [KEY_W-1:0] pend_key_r;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic [FW-1:0]           fill_id;
  logic                    split;
  logic [PW-1:0]           fresh;
  logic [FW-1:0]           pos;
  logic                    dup;
  logic signed [KEY_W-1:0] shifted [LEAF_KEYS+1];
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [KEY_W-1:0]        ram_rdata;
  logic signed [KEY_W-1:0] v;
  logic                    out_free;

  assign fill_id  = fill_r[id_r];
  assign split    = (fill_id == FW'(LEAF_KEYS));
  assign fresh    = used_r[PW-1:0];
  assign v        = $signed(ram_rdata);
  assign out_free = !out_valid_r || !out_stall;

  // sorted insert position and duplicate check over the loaded leaf
  always_comb begin
    pos = '0;
    dup = 1'b0;
    for (int i = 0; i < LEAF_KEYS; i++) begin
      if (FW'(i) < fill_id && buf_r[i] < key_r) begin
        pos = pos + FW'(1);
      end
      if (FW'(i) < fill_id && buf_r[i] == key_r) begin
        dup = 1'b1;
      end
    end
    shifted[0] = (pos == '0) ? key_r : buf_r[0];
    for (int i = 1; i <= LEAF_KEYS; i++) begin
      if (FW'(i) < pos) begin
        shifted[i] = buf_r[i];
      end else if (FW'(i) == pos) begin
        shifted[i] = key_r;
      end else begin
        shifted[i] = buf_r[i-1];
      end
    end
  end

  assign ram_we    = cmd.wr_step;
  assign ram_waddr = (split && idx_r >= FW'(SPLIT_KEEP))
                   ? AW'(fresh) * AW'(LEAF_KEYS) + AW'(idx_r - FW'(SPLIT_KEEP))
                   : AW'(id_r) * AW'(LEAF_KEYS) + AW'(idx_r);
  assign ram_re    = cmd.load_rd || cmd.sep_rd || cmd.scan_rd;
  assign ram_raddr = cmd.sep_rd ? AW'(order_r[sepi_r[PW-1:0]]) * AW'(LEAF_KEYS)
                   : AW'(id_r) * AW'(LEAF_KEYS) + AW'(idx_r);

  bpli_ram #(
    .WIDTH(KEY_W),
    .DEPTH(DEPTH)
  ) u_keys (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(buf_r[idx_r]),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r <= in_item.func;
      key_r  <= in_item.key;
      hi_r   <= in_item.high_key;
      slot_r <= '0;
    end
    if (cmd.route_step) begin
      slot_r <= slot_r + PW'(1);
    end
    if (cmd.set_id) begin
      id_r   <= order_r[slot_r];
      idx_r  <= '0;
      hops_r <= '0;
    end
    if (cmd.load_wr) begin
      buf_r[idx_r] <= v;
      idx_r        <= idx_r + FW'(1);
    end
    if (cmd.ins_shift) begin
      buf_r <= shifted;
      idx_r <= '0;
    end
    if (cmd.wr_step || cmd.scan_adv) begin
      idx_r <= idx_r + FW'(1);
    end
    if (cmd.meta_upd) begin
      sepi_r <= UW'(1);
    end
    if (cmd.sep_wr) begin
      sep_r[PW'(sepi_r - UW'(1))] <= v;
      sepi_r                      <= sepi_r + UW'(1);
    end
    if (cmd.scan_adv && v >= key_r) begin
      pend_key_r <= v;
    end
    if (cmd.next_leaf) begin
      id_r   <= link_r[id_r];
      idx_r  <= '0;
      hops_r <= hops_r + PW'(1);
    end
    if (cmd.put) begin
      out_item_r.status <= cmd.put_status;
      out_item_r.value  <= cmd.put_pend ? pend_key_r : '0;
      out_item_r.leaf   <= (cmd.put_status == ST_LEAF) ? LEAF_W'(id_r) : '0;
      out_item_r.last   <= cmd.put_last;
    end
  end

  // tree metadata and handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '{default: '0};
      link_r       <= '{default: '1};
      lv_r         <= '{default: 1'b0};
      order_r      <= '{default: '0};
      used_r       <= UW'(1);
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.meta_upd) begin
        if (!split) begin
          fill_r[id_r] <= fill_id + FW'(1);
        end else begin
          fill_r[id_r]  <= FW'(SPLIT_KEEP);
          fill_r[fresh] <= FW'(LEAF_KEYS + 1 - SPLIT_KEEP);
          link_r[fresh] <= link_r[id_r];
          lv_r[fresh]   <= lv_r[id_r];
          link_r[id_r]  <= fresh;
          lv_r[id_r]    <= 1'b1;
          // open a child slot right after the split leaf
          for (int i = 1; i < LEAF_PAGES; i++) begin
            if (UW'(i) == UW'(slot_r) + UW'(1)) begin
              order_r[i] <= fresh;
            end else if (UW'(i) > UW'(slot_r) + UW'(1) && UW'(i) <= used_r) begin
              order_r[i] <= order_r[i-1];
            end
          end
          used_r <= used_r + UW'(1);
        end
      end
      if (cmd.set_id) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.scan_adv && v >= key_r) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.put) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.func       = func_r;
  assign sts.inv        = key_r > hi_r;
  assign sts.route_more = (UW'(slot_r) + UW'(1) < used_r) && (key_r >= sep_r[slot_r]);
  assign sts.load_last  = (idx_r == FW'(LEAF_KEYS - 1));
  assign sts.dup        = dup;
  assign sts.full       = split && (used_r == UW'(LEAF_PAGES));
  assign sts.wr_last    = (idx_r == fill_id);
  assign sts.sep_done   = (sepi_r >= used_r);
  assign sts.leaf_end   = (idx_r >= fill_id);
  assign sts.leaf_more  = lv_r[id_r] && (UW'(link_r[id_r]) < UW'(LEAF_PAGES))
                       && (UW'(hops_r) + UW'(1) < UW'(LEAF_PAGES));
  assign sts.v_gt_hi    = v > hi_r;
  assign sts.v_ge_lo    = v >= key_r;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> out_free)
    else $error("result written over an untaken word");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r >= UW'(1)) && (used_r <= UW'(LEAF_PAGES)))
    else $error("leaf count out of range");

  a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.meta_upd && split) |=> used_r == $past(used_r) + UW'(1))
    else $error("split did not add a leaf");

  a_wr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_step |-> idx_r <= FW'(LEAF_KEYS))
    else $error("write back ran past the leaf buffer");

endmodule

// File: hw/rtl/bpli_ctrl.sv
// bpli_ctrl: sequencer for routing, leaf load, insert write back, separator refresh
// and chained scans; depends on bpli_pkg
module bpli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bpli_pkg::sts_t sts,
  output bpli_pkg::cmd_t cmd
);
  import bpli_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_ROUTE  = 13'h0002,
    S_LRD    = 13'h0004,
    S_LWR    = 13'h0008,
    S_DECIDE = 13'h0010,
    S_WR     = 13'h0020,
    S_META   = 13'h0040,
    S_SEPR   = 13'h0080,
    S_SEPW   = 13'h0100,
    S_SRD    = 13'h0200,
    S_SUSE   = 13'h0400,
    S_SFIN   = 13'h0800,
    S_RESP   = 13'h1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (sts.func == FN_SCAN && sts.inv) begin
          res_nxt   = ST_EMPTY;
          state_nxt = S_RESP;
        end else if (sts.route_more) begin
          cmd.route_step = 1'b1;
        end else begin
          cmd.set_id = 1'b1;
          if (sts.func == FN_QUERY) begin
            res_nxt   = ST_LEAF;
            state_nxt = S_RESP;
          end else if (sts.func == FN_SCAN) begin
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_LRD;
          end
        end
      end
      S_LRD: begin
        cmd.load_rd = 1'b1;
        state_nxt   = S_LWR;
      end
      S_LWR: begin
        cmd.load_wr = 1'b1;
        state_nxt   = sts.load_last ? S_DECIDE : S_LRD;
      end
      S_DECIDE: begin
        priority if (sts.func == FN_LOOKUP) begin
          res_nxt   = sts.dup ? ST_FOUND : ST_ABSENT;
          state_nxt = S_RESP;
        end else if (sts.dup) begin
          res_nxt   = ST_DUP;
          state_nxt = S_RESP;
        end else if (sts.full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_RESP;
        end else begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_step = 1'b1;
        if (sts.wr_last) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        cmd.meta_upd = 1'b1;
        state_nxt    = S_SEPR;
      end
      S_SEPR: begin
        if (sts.sep_done) begin
          res_nxt   = ST_INSERTED;
          state_nxt = S_RESP;
        end else begin
          cmd.sep_rd = 1'b1;
          state_nxt  = S_SEPW;
        end
      end
      S_SEPW: begin
        cmd.sep_wr = 1'b1;
        state_nxt  = S_SEPR;
      end
      S_SRD: begin
        if (sts.leaf_end) begin
          if (sts.leaf_more) begin
            cmd.next_leaf = 1'b1;
          end else begin
            state_nxt = S_SFIN;
          end
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SUSE;
        end
      end
      S_SUSE: begin
        if (sts.v_gt_hi) begin
          state_nxt = S_SFIN;
        end else if (sts.v_ge_lo && sts.pend_valid) begin
          // the held key is known not to be the final one
          if (sts.out_free) begin
            cmd.put        = 1'b1;
            cmd.put_pend   = 1'b1;
            cmd.put_status = ST_SCAN_KEY;
            cmd.scan_adv   = 1'b1;
            state_nxt      = S_SRD;
          end
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SRD;
        end
      end
      S_SFIN: begin
        if (sts.out_free) begin
          cmd.put        = 1'b1;
          cmd.put_last   = 1'b1;
          cmd.put_pend   = sts.pend_valid;
          cmd.put_status = sts.pend_valid ? ST_SCAN_KEY : ST_EMPTY;
          state_nxt      = S_IDLE;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.put        = 1'b1;
          cmd.put_last   = 1'b1;
          cmd.put_status = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
